// ===== hw/rtl/pwbu_pkg.sv =====
`timescale 1ns / 1ps
package pwbu_pkg;

    localparam int DATA_W = 32;
    localparam int SUM_W  = 48;
    localparam int DIV_W  = 33;

    localparam logic [1:0] MODE_OPEN    = 2'd0;
    localparam logic [1:0] MODE_WRAP    = 2'd1;
    localparam logic [1:0] MODE_REFLECT = 2'd2;
    localparam logic [1:0] MODE_REPEL   = 2'd3;

    localparam logic [2:0] REG_LOWER   = 3'd0;
    localparam logic [2:0] REG_UPPER   = 3'd1;
    localparam logic [2:0] REG_MODE    = 3'd2;
    localparam logic [2:0] REG_KGAIN   = 3'd3;
    localparam logic [2:0] REG_CGAIN   = 3'd4;

    localparam logic [SUM_W-1:0] SUM_CAP = {1'b0, {(SUM_W-1){1'b1}}};

    // datapath commands from the controller
    typedef struct packed {
        logic load;       // capture input item, clear sums on first
        logic div_start;  // start remainder
        logic div_step;   // one restoring step
        logic mul_a;      // kd = k*depth, dd = c*vout
        logic mul_b;      // d2 = depth*depth
        logic mul_c;      // e = k*d2
        logic finish;     // form result and update sums
    } pwbu_cmd_t;

    // datapath status to the controller
    typedef struct packed {
        logic need_div;
        logic need_repel;
    } pwbu_sts_t;

    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [34:0] x);
        if (x > 35'sd2147483647) return 32'sh7fffffff;
        if (x < -35'sd2147483648) return 32'sh80000000;
        return x[DATA_W-1:0];
    endfunction

endpackage

// ===== hw/rtl/pwbu_ctrl.sv =====
`timescale 1ns / 1ps
module pwbu_ctrl
    import pwbu_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      in_fire,
    input  logic      out_fire,
    input  pwbu_sts_t sts,
    output logic      busy,
    output logic      out_valid,
    output pwbu_cmd_t cmd
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_DEC  = 3'd1;
    localparam logic [2:0] ST_DIV  = 3'd2;
    localparam logic [2:0] ST_MA   = 3'd3;
    localparam logic [2:0] ST_MB   = 3'd4;
    localparam logic [2:0] ST_MC   = 3'd5;
    localparam logic [2:0] ST_FIN  = 3'd6;
    localparam logic [2:0] ST_OUT  = 3'd7;

    logic [2:0] state_reg, state_next;
    logic [5:0] cnt_reg, cnt_next;

    assign busy      = (state_reg != ST_IDLE);
    assign out_valid = (state_reg == ST_OUT);

    // sequence one item through the datapath
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    cmd.load   = 1'b1;
                    state_next = ST_DEC;
                end
            end
            ST_DEC: begin
                if (sts.need_div) begin
                    cmd.div_start = 1'b1;
                    cnt_next      = 6'(DIV_W);
                    state_next    = ST_DIV;
                end else if (sts.need_repel) begin
                    cmd.mul_a  = 1'b1;
                    state_next = ST_MB;
                end else begin
                    state_next = ST_FIN;
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg - 6'd1;
                if (cnt_reg == 6'd1) state_next = ST_FIN;
            end
            ST_MA: begin
                cmd.mul_a  = 1'b1;
                state_next = ST_MB;
            end
            ST_MB: begin
                cmd.mul_b  = 1'b1;
                state_next = ST_MC;
            end
            ST_MC: begin
                cmd.mul_c  = 1'b1;
                state_next = ST_FIN;
            end
            ST_FIN: begin
                cmd.finish = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (out_fire) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    a_div_count: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_DIV |-> cnt_reg != 6'd0) else $error("divider count ran out");
    a_one_hot_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(cmd)) else $error("more than one datapath command");
    a_out_after_fin: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |=> out_valid) else $error("result not presented after finish");

endmodule

// ===== hw/rtl/pwbu_dp.sv =====
`timescale 1ns / 1ps
module pwbu_dp
    import pwbu_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  pwbu_cmd_t                cmd,
    output pwbu_sts_t                sts,
    input  logic signed [DATA_W-1:0] lower_bound,
    input  logic signed [DATA_W-1:0] upper_bound,
    input  logic [1:0]               boundary_mode,
    input  logic [30:0]              repulsion_gain,
    input  logic [30:0]              damping_gain,
    input  logic                     in_op,
    input  logic signed [DATA_W-1:0] in_position,
    input  logic signed [DATA_W-1:0] in_velocity,
    input  logic signed [DATA_W-1:0] in_force_req,
    input  logic signed [DATA_W-1:0] in_other_position,
    input  logic                     in_first,
    output logic signed [DATA_W-1:0] new_position,
    output logic signed [DATA_W-1:0] new_velocity,
    output logic signed [DATA_W-1:0] new_force,
    output logic signed [DATA_W-1:0] displacement,
    output logic signed [SUM_W-1:0]  wall_force_sum,
    output logic [SUM_W-2:0]         wall_energy_sum
);

    logic                     op_reg;
    logic signed [DATA_W-1:0] pos_reg, vel_reg, frc_reg, oth_reg;
    logic [SUM_W-1:0]         ftot_reg, etot_reg;
    logic [DIV_W-1:0]         rem_reg, quo_reg, dvs_reg;
    logic [63:0]              kd_reg, dd_reg, d2_reg, e_reg;
    logic signed [DATA_W-1:0] np_reg, nv_reg, nf_reg, disp_reg;

    // geometry, all 34-bit signed
    logic signed [33:0] lo, up, p, width, dlow, dhigh, mdisp, adisp, dx;
    logic               below, above_w, above_s, wok, hit;
    logic [31:0]        depth, vout;
    logic signed [33:0] vo;
    logic [DIV_W-1:0]   num;

    assign lo      = 34'(lower_bound);
    assign up      = 34'(upper_bound);
    assign p       = 34'(pos_reg);
    assign width   = up - lo;
    assign wok     = width > 34'sd0;
    assign below   = p < lo;
    assign above_w = p >= up;
    assign above_s = p > up;
    assign dlow    = lo - p;
    assign dhigh   = p - up;
    assign hit     = below | above_s;
    assign depth   = below ? dlow[31:0] : dhigh[31:0];
    assign vo      = below ? -34'(vel_reg) : 34'(vel_reg);
    assign vout    = (vo > 34'sd0) ? vo[31:0] : 32'd0;
    assign num     = below ? dlow[DIV_W-1:0] : 33'(p - lo);

    assign sts.need_div   = !op_reg && boundary_mode == MODE_WRAP && wok && (below | above_w);
    assign sts.need_repel = !op_reg && boundary_mode == MODE_REPEL && hit;

    assign mdisp = p - 34'(oth_reg);
    assign adisp = mdisp[33] ? -mdisp : mdisp;
    assign dx    = width - adisp;

    // restoring remainder step
    logic [DIV_W:0] trial;
    assign trial = {rem_reg, quo_reg[DIV_W-1]} - {1'b0, dvs_reg};

    // k*d2 from two partial products, d2 split at bit 32
    logic [79:0] eprod;
    assign eprod = 80'(repulsion_gain) * 80'(d2_reg[31:0])
                 + ((80'(repulsion_gain) * 80'(d2_reg[47:32])) << 32);

    // force and energy terms
    logic [63:0] kdc, ddc, ec, fsum, f, ftn, etn;
    assign kdc  = (kd_reg > 64'(SUM_CAP)) ? 64'(SUM_CAP) : kd_reg;
    assign ddc  = (dd_reg > 64'(SUM_CAP)) ? 64'(SUM_CAP) : dd_reg;
    assign ec   = (e_reg > 64'(SUM_CAP)) ? 64'(SUM_CAP) : e_reg;
    assign fsum = (kdc * 64'd10) + ddc;
    assign f    = (fsum > 64'(SUM_CAP)) ? 64'(SUM_CAP) : fsum;
    assign ftn  = 64'(ftot_reg) + f;
    assign etn  = 64'(etot_reg) + ec;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ftot_reg <= '0;
            etot_reg <= '0;
        end else begin
            if (cmd.load && in_first) begin
                ftot_reg <= '0;
                etot_reg <= '0;
            end
            if (cmd.finish && sts.need_repel) begin
                ftot_reg <= (ftn > 64'(SUM_CAP)) ? SUM_CAP : ftn[SUM_W-1:0];
                etot_reg <= (etn > 64'(SUM_CAP)) ? SUM_CAP : etn[SUM_W-1:0];
            end
        end
    end

    // capture item, iterate remainder, run the multiplies, form the result
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg  <= in_op;
            pos_reg <= in_position;
            vel_reg <= in_velocity;
            frc_reg <= in_force_req;
            oth_reg <= in_other_position;
        end
        if (cmd.div_start) begin
            rem_reg <= '0;
            quo_reg <= num;
            dvs_reg <= width[DIV_W-1:0];
        end
        if (cmd.div_step) begin
            quo_reg <= {quo_reg[DIV_W-2:0], 1'b0};
            rem_reg <= trial[DIV_W] ? {rem_reg[DIV_W-2:0], quo_reg[DIV_W-1]}
                                    : trial[DIV_W-1:0];
        end
        if (cmd.mul_a) begin
            kd_reg <= (64'(repulsion_gain) * 64'(depth)) >> 16;
            dd_reg <= (64'(damping_gain) * 64'(vout)) >> 16;
        end
        if (cmd.mul_b) begin
            d2_reg <= (64'(depth) * 64'(depth)) >> 16;
        end
        if (cmd.mul_c) begin
            e_reg <= {1'b0, eprod[79:17]};
        end
        if (cmd.finish) begin
            np_reg   <= '0;
            nv_reg   <= '0;
            nf_reg   <= '0;
            disp_reg <= '0;
            if (op_reg) begin
                if (boundary_mode == MODE_WRAP && wok && dx < adisp)
                    disp_reg <= sat32(35'(mdisp[33] ? dx : -dx));
                else
                    disp_reg <= sat32(35'(mdisp));
            end else begin
                np_reg <= pos_reg;
                nv_reg <= vel_reg;
                nf_reg <= frc_reg;
                case (boundary_mode)
                    MODE_WRAP: begin
                        if (sts.need_div) begin
                            if (below)
                                np_reg <= (rem_reg == '0) ? lower_bound
                                          : 32'(up - 34'(rem_reg));
                            else
                                np_reg <= 32'(lo + 34'(rem_reg));
                        end
                    end
                    MODE_REFLECT: begin
                        if (hit) begin
                            np_reg <= sat32(35'(below ? lo : up) * 35'sd2 - 35'(p));
                            nv_reg <= sat32(-35'(vel_reg));
                        end
                    end
                    MODE_REPEL: begin
                        if (hit)
                            nf_reg <= sat32(below ? 35'(frc_reg) + 35'(f[33:0])
                                : 35'(frc_reg) - 35'(f[33:0]));
                    end
                    default: ;
                endcase
                if (boundary_mode == MODE_REPEL && hit && f > 64'h3_0000_0000) begin
                    nf_reg <= below ? 32'sh7fffffff : 32'sh80000000;
                end
            end
        end
    end

    assign new_position    = np_reg;
    assign new_velocity    = nv_reg;
    assign new_force       = nf_reg;
    assign displacement    = disp_reg;
    assign wall_force_sum  = ftot_reg;
    assign wall_energy_sum = etot_reg[SUM_W-2:0];

    a_sum_cap_f: assert property (@(posedge aclk) disable iff (!aresetn)
        ftot_reg <= SUM_CAP) else $error("force sum above cap");
    a_sum_cap_e: assert property (@(posedge aclk) disable iff (!aresetn)
        etot_reg <= SUM_CAP) else $error("energy sum above cap");
    a_div_order: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_step |-> !cmd.mul_a) else $error("divider and multiplier overlap");

endmodule

// ===== hw/rtl/particle_wall_boundary_unit_core.sv =====
`timescale 1ns / 1ps
// Path: open, reflect, displacement and in-box items go from decode straight to
// finish; repel beyond a wall runs the multiply steps first, and periodic wrap of
// a particle outside a non-empty box runs the restoring remainder (33-step remainder).
// Flow: one item at a time; the next input transfer is taken in the
// cycle after the result transfer. The remainder unit sets the longest path.
// Reset (aresetn low, synchronous) clears the sums, the configuration registers to their
// defaults and returns the controller to idle.
module particle_wall_boundary_unit_core
    import pwbu_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          cfg_we,
    input  logic [2:0]    cfg_index,
    input  logic [31:0]   cfg_data,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [127:0]  s_tdata,   // position, velocity, force_req, other_position
    input  logic [1:0]    s_tuser,   // op, first
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [223:0]  m_tdata    // new_position, new_velocity, new_force,
                                     // displacement, wall_force_sum, wall_energy_sum, pad
);

    logic signed [31:0] lower_reg, upper_reg;
    logic [1:0]         mode_reg;
    logic [30:0]        kgain_reg, cgain_reg;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lower_reg <= 32'sd0;
            upper_reg <= 32'sd65536;
            mode_reg  <= MODE_WRAP;
            kgain_reg <= 31'd65536;
            cgain_reg <= 31'd0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_LOWER: lower_reg <= cfg_data;
                REG_UPPER: upper_reg <= cfg_data;
                REG_MODE:  mode_reg  <= cfg_data[1:0];
                REG_KGAIN: kgain_reg <= cfg_data[30:0];
                REG_CGAIN: cgain_reg <= cfg_data[30:0];
                default: ;
            endcase
        end
    end

    pwbu_cmd_t cmd;
    pwbu_sts_t sts;
    logic      busy, in_fire, out_fire;

    assign s_tready = !busy;
    assign in_fire  = s_tvalid && s_tready;
    assign out_fire = m_tvalid && m_tready;

    pwbu_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .in_fire(in_fire), .out_fire(out_fire),
        .sts(sts), .busy(busy), .out_valid(m_tvalid), .cmd(cmd)
    );

    logic signed [31:0] np, nv, nf, dp;
    logic signed [47:0] fs;
    logic [46:0]        es;

    pwbu_dp u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .sts(sts),
        .lower_bound(lower_reg), .upper_bound(upper_reg), .boundary_mode(mode_reg),
        .repulsion_gain(kgain_reg), .damping_gain(cgain_reg),
        .in_op(s_tuser[0]), .in_position(s_tdata[31:0]),
        .in_velocity(s_tdata[63:32]), .in_force_req(s_tdata[95:64]),
        .in_other_position(s_tdata[127:96]), .in_first(s_tuser[1]),
        .new_position(np), .new_velocity(nv), .new_force(nf), .displacement(dp),
        .wall_force_sum(fs), .wall_energy_sum(es)
    );

    assign m_tdata = {1'b0, es, fs, dp, nf, nv, np};

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
module tb;
    import pwbu_pkg::*;

    localparam logic OP_APPLY = 1'b0;
    localparam logic OP_DISP  = 1'b1;
    localparam int   CYCLE_LIMIT = 1000000;
    localparam int   ITEMS_PER_PHASE = 155;
    localparam int   NUM_PHASES = 9;

    typedef struct {
        logic               op;
        logic               first;
        logic signed [31:0] pos;
        logic signed [31:0] vel;
        logic signed [31:0] frc;
        logic signed [31:0] oth;
    } particle_t;

    typedef struct packed {
        logic signed [31:0] pos;
        logic signed [31:0] vel;
        logic signed [31:0] frc;
        logic signed [31:0] disp;
        logic [47:0]        fsum;
        logic [46:0]        esum;
    } boundary_result_t;

    logic          aclk = 1'b0;
    logic          aresetn = 1'b0;
    logic          cfg_we = 1'b0;
    logic [2:0]    cfg_index = '0;
    logic [31:0]   cfg_data = '0;
    logic          s_tvalid = 1'b0;
    logic          s_tready;
    logic [127:0]  s_tdata = '0;
    logic [1:0]    s_tuser = '0;
    logic          m_tvalid;
    logic          m_tready = 1'b0;
    logic [223:0]  m_tdata;

    particle_t        pending_items[$];
    boundary_result_t expected_results[$];
    particle_t        cur_item;

    // shadow of the block's registers and sums
    longint           lo_wall = 0;
    longint           hi_wall = 65536;
    logic [1:0]       mode = MODE_WRAP;
    longint unsigned  k_gain = 65536;
    longint unsigned  c_gain = 0;
    longint unsigned  force_acc = 0;
    longint unsigned  energy_acc = 0;

    int send_idle = 0;
    int recv_idle = 0;
    int items_sent = 0;
    int results_seen = 0;
    int mismatches = 0;
    int cycles = 0;
    int hold_left = 0;
    bit hold_done = 0;

    particle_wall_boundary_unit_core i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    function automatic longint clamp_word(longint x);
        if (x > 64'sd2147483647) return 64'sd2147483647;
        if (x < -64'sd2147483648) return -64'sd2147483648;
        return x;
    endfunction

    // floor(a*b / 2^sh), capped at the sum limit
    function automatic longint unsigned scaled_product(longint unsigned a, longint unsigned b,
                                                       int sh);
        logic [127:0] q;
        q = ({64'd0, a} * {64'd0, b}) >> sh;
        return (q > SUM_CAP) ? SUM_CAP : q[63:0];
    endfunction

    function automatic longint unsigned cap_sum(longint unsigned a, longint unsigned b);
        longint unsigned s;
        s = a + b;
        return (s > SUM_CAP) ? SUM_CAP : s;
    endfunction

    function automatic boundary_result_t apply_boundary(particle_t it);
        boundary_result_t res;
        longint p, v, f, o, w, np, nv, nf, d, a, dx;
        longint unsigned r, depth, vout, kd, dd, fw, d2, e;
        bit low, high;
        p = it.pos; v = it.vel; f = it.frc; o = it.oth;
        w = hi_wall - lo_wall;
        np = 0; nv = 0; nf = 0; d = 0;
        if (it.first) begin
            force_acc = 0;
            energy_acc = 0;
        end
        if (it.op == OP_DISP) begin
            d = p - o;
            if (mode == MODE_WRAP && w > 0) begin
                a = (d < 0) ? -d : d;
                dx = w - a;
                if (dx < a) d = (d > 0) ? -dx : dx;
            end
            d = clamp_word(d);
        end else begin
            np = p; nv = v; nf = f;
            if (mode == MODE_WRAP) begin
                if (w > 0) begin
                    if (p < lo_wall) begin
                        r = longint'(lo_wall - p) % w;
                        np = (r == 0) ? lo_wall : hi_wall - longint'(r);
                    end else if (p >= hi_wall) begin
                        np = lo_wall + ((p - lo_wall) % w);
                    end
                end
            end else if (mode == MODE_REFLECT) begin
                if (p < lo_wall) begin
                    np = clamp_word(2 * lo_wall - p);
                    nv = clamp_word(-v);
                end else if (p > hi_wall) begin
                    np = clamp_word(2 * hi_wall - p);
                    nv = clamp_word(-v);
                end
            end else if (mode == MODE_REPEL) begin
                low = p < lo_wall;
                high = p > hi_wall;
                if (low || high) begin
                    depth = low ? lo_wall - p : p - hi_wall;
                    a = low ? -v : v;
                    vout = (a > 0) ? a : 0;
                    kd = scaled_product(k_gain, depth, 16);
                    dd = scaled_product(c_gain, vout, 16);
                    fw = cap_sum(10 * kd, dd);
                    nf = clamp_word(low ? f + longint'(fw) : f - longint'(fw));
                    force_acc = cap_sum(force_acc, fw);
                    // depth squared is below 2^64 and is not capped
                    d2 = (depth * depth) >> 16;
                    e = scaled_product(k_gain, d2, 17);
                    energy_acc = cap_sum(energy_acc, e);
                end
            end
        end
        res.pos = np[31:0];
        res.vel = nv[31:0];
        res.frc = nf[31:0];
        res.disp = d[31:0];
        res.fsum = force_acc[47:0];
        res.esum = energy_acc[46:0];
        return res;
    endfunction

    // append one item to the stimulus queue
    function automatic void queue_item(particle_t it);
        pending_items = {pending_items, it};
    endfunction

    // driver: predict on each accepted transfer, then offer the next item
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                expected_results = {expected_results, apply_boundary(cur_item)};
                items_sent <= items_sent + 1;
            end
            if (!s_tvalid || s_tready) begin
                if (pending_items.size() > 0 && $urandom_range(99) >= send_idle) begin
                    cur_item = pending_items.pop_front();
                    s_tdata <= {cur_item.oth, cur_item.frc, cur_item.vel, cur_item.pos};
                    s_tuser <= {cur_item.first, cur_item.op};
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver: random stalls plus one long hold to back up the block
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready <= 1'b0;
        end else if (!hold_done && items_sent >= 400) begin
            hold_left <= 300;
            hold_done <= 1'b1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle);
        end
    end

    // monitor: compare each result transfer with the oldest prediction
    always @(posedge aclk) begin
        boundary_result_t exp_r, got;
        if (aresetn && m_tvalid && m_tready) begin
            got.pos  = m_tdata[31:0];
            got.vel  = m_tdata[63:32];
            got.frc  = m_tdata[95:64];
            got.disp = m_tdata[127:96];
            got.fsum = m_tdata[175:128];
            got.esum = m_tdata[222:176];
            results_seen <= results_seen + 1;
            if (expected_results.size() == 0) begin
                mismatches <= mismatches + 1;
                if (mismatches < 10) $display("unexpected result transfer: %h", m_tdata);
            end else begin
                exp_r = expected_results.pop_front();
                if (got != exp_r) begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10)
                        $display("mismatch: exp pos %h vel %h frc %h disp %h fsum %h esum %h\n",
                                 exp_r.pos, exp_r.vel, exp_r.frc, exp_r.disp, exp_r.fsum,
                                 exp_r.esum,
                                 "          got pos %h vel %h frc %h disp %h fsum %h esum %h",
                                 got.pos, got.vel, got.frc, got.disp, got.fsum, got.esum);
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("FAILURE");
            $finish;
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            REG_LOWER: lo_wall = longint'(signed'(val));
            REG_UPPER: hi_wall = longint'(signed'(val));
            REG_MODE:  mode = val[1:0];
            REG_KGAIN: k_gain = val[30:0];
            REG_CGAIN: c_gain = val[30:0];
            default: ;
        endcase
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic setup_box(logic [31:0] lo, logic [31:0] hi, logic [1:0] m,
                             logic [31:0] k, logic [31:0] c);
        write_reg(REG_LOWER, lo);
        write_reg(REG_UPPER, hi);
        write_reg(REG_MODE, m);
        write_reg(REG_KGAIN, k);
        write_reg(REG_CGAIN, c);
    endtask

    task automatic drain();
        while (pending_items.size() > 0 || s_tvalid || expected_results.size() > 0)
            @(posedge aclk);
        repeat (45) @(posedge aclk);
    endtask

    function automatic logic [31:0] pick_coord();
        int sel;
        longint span;
        sel = $urandom_range(9);
        span = (hi_wall > lo_wall) ? hi_wall - lo_wall : 65536;
        case (sel)
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return lo_wall[31:0] + $urandom_range(2) - 1;
            3: return hi_wall[31:0] + $urandom_range(2) - 1;
            4, 5: return $urandom;
            default: return lo_wall[31:0] - span[31:0] * 2 + $urandom_range(span * 5 > 64'hffff_ffff ?
                            32'hffff_ffff : span * 5);
        endcase
    endfunction

    function automatic particle_t random_particle();
        particle_t it;
        it.op = ($urandom_range(99) < 30) ? OP_DISP : OP_APPLY;
        it.first = ($urandom_range(99) < 10);
        it.pos = pick_coord();
        it.vel = ($urandom_range(3) == 0) ? pick_coord() : $urandom;
        it.frc = ($urandom_range(4) == 0) ? pick_coord() : $urandom;
        it.oth = pick_coord();
        return it;
    endfunction

    function automatic particle_t mk(logic op, logic first, logic [31:0] p, logic [31:0] v,
                                     logic [31:0] f, logic [31:0] o);
        particle_t it;
        it.op = op; it.first = first; it.pos = p; it.vel = v; it.frc = f; it.oth = o;
        return it;
    endfunction

    initial begin
        logic [31:0] lo, hi;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // directed items at reset settings: wrap in [0, 1.0)
        queue_item(mk(OP_APPLY, 1, 32'hffff_ffff, 32'h7fff_ffff, 0, 0));
        queue_item(mk(OP_APPLY, 0, 32'h0001_0000, 32'h8000_0000, 1, 0));
        queue_item(mk(OP_APPLY, 0, 32'hffff_0000, 0, 32'h7fff_ffff, 0));
        queue_item(mk(OP_APPLY, 0, 32'hfffd_0000, 1, 2, 3));
        queue_item(mk(OP_APPLY, 0, 32'h7fff_ffff, 5, 6, 7));
        queue_item(mk(OP_APPLY, 0, 32'h8000_0000, 5, 6, 7));
        queue_item(mk(OP_APPLY, 0, 32'h0000_8000, 5, 6, 7));
        queue_item(mk(OP_APPLY, 0, 0, 5, 6, 7));
        queue_item(mk(OP_DISP, 0, 32'h7fff_ffff, 1, 1, 32'h8000_0000));
        queue_item(mk(OP_DISP, 0, 32'h8000_0000, 1, 1, 32'h7fff_ffff));
        queue_item(mk(OP_DISP, 0, 32'h0000_c000, 0, 0, 0));
        queue_item(mk(OP_DISP, 1, 32'h0000_8000, 0, 0, 0));
        queue_item(mk(OP_DISP, 0, 32'h0000_4000, 0, 0, 0));
        drain();

        for (int ph = 1; ph <= NUM_PHASES; ph++) begin
            send_idle = (ph <= 3) ? 27 : (ph <= 6) ? 62 : 0;
            recv_idle = (ph <= 3) ? 62 : (ph <= 6) ? 27 : 0;
            case (ph)
                1: setup_box(-32'sd327680, 32'sd458752, MODE_WRAP, 32'd65536, 32'd0);
                2: setup_box(32'd0, 32'd655360, MODE_REFLECT, 32'd100, 32'd5);
                3: setup_box(-32'sd131072, 32'sd131072, MODE_REPEL, 32'd65536, 32'd32768);
                4: setup_box(32'h8000_0000, 32'h7fff_ffff, MODE_REPEL, 32'h7fff_ffff,
                             32'h7fff_ffff);
                5: setup_box($urandom, $urandom, MODE_OPEN, $urandom, $urandom);
                6: setup_box(32'h8000_0000, 32'h7fff_ffff, MODE_WRAP, 32'd0, 32'd0);
                7: setup_box(32'd655360, -32'sd655360, MODE_WRAP, 32'd1, 32'd1);
                8: setup_box(32'h7fff_0000, 32'h8000_ffff, MODE_REFLECT, 32'd3, 32'd0);
                default: begin
                    lo = $urandom_range(32'h00ff_ffff) - 32'h0080_0000;
                    hi = lo + $urandom_range(32'h00ff_ffff) + 1;
                    setup_box(lo, hi, MODE_REPEL, $urandom & 32'h0007_ffff,
                              $urandom & 32'h7fff_ffff);
                end
            endcase
            // a repel item just past each wall, on top of random ones
            if (mode == MODE_REPEL) begin
                queue_item(mk(OP_APPLY, 1, lo_wall[31:0] - 1, 32'h8000_0000,
                              32'h7fff_ffff, 0));
                queue_item(mk(OP_APPLY, 0, hi_wall[31:0] + 1, 32'h7fff_ffff,
                              32'h8000_0000, 0));
            end
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
                queue_item(random_particle());
            drain();
        end

        $display("ran %0d particle items over %0d box settings, %0d results checked",
                 items_sent, NUM_PHASES + 1, results_seen);
        $display("modes open, wrap, reflect and repel, incl. extreme and empty boxes");
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("FAILURE");
        end
        $finish;
    end

endmodule
